/* rtl/core/flrw_pkg.sv */
// shared types and constants of the flash ring log writer
package flrw_pkg;

  localparam int ADDR_W    = 27;
  localparam int JOB_BYTES = 10;
  localparam int NB_W      = 4;
  localparam int QDEPTH    = 4;
  localparam int QPTR_W    = 2;
  localparam int QCNT_W    = 3;

  localparam logic [15:0] LOG_MAGIC = 16'hAA55;

  typedef enum logic [1:0] {
    OP_INIT    = 2'd0,
    OP_BEGIN   = 2'd1,
    OP_PAYLOAD = 2'd2
  } flrw_op_t;

  typedef enum logic [1:0] {
    CMD_ERASE  = 2'd0,
    CMD_WRITE  = 2'd1,
    CMD_REJECT = 2'd2
  } flrw_cmd_t;

  // one classified item: a reject, or an optional erase, then nbytes writes from base
  typedef struct packed {
    logic                        reject;
    logic                        erase;
    logic [ADDR_W-1:0]           erase_addr;
    logic [NB_W-1:0]             nbytes;
    logic [ADDR_W-1:0]           base;
    logic [JOB_BYTES-1:0][7:0]   bytes;
  } flrw_job_t;

endpackage

/* rtl/core/flash_ring_log_writer_unit.sv */
// Flash ring log writer: turns log records into NOR flash erase and write commands.
// Input stream s_*: one word per item, kind in s_tuser (init, begin, payload byte).
// Output stream m_*: one command word per result; m_tlast marks the final word
// caused by an input item, m_tuser carries the command (erase, write, reject).
// The front end takes one input word per cycle whenever its job queue has room
// and updates the write pointer, record state and checksum at once.
// The back end drains the queue through an output register, one word per cycle
// while m_tready is high. With the queue empty, an input word goes to a queue
// slot and then to the output register as its first output word. A payload byte
// gives one word (two on the record's last byte), so a payload stream runs at
// one byte per cycle while m_tready is high; a begin item gives up to 11 words
// (erase, nine header bytes, checksum) and holds the output side that long,
// while the four-entry queue keeps taking further input words. When m_tready is
// low the output word holds, the queue fills and s_tready drops once four jobs
// wait. Reset empties the queue and output, clears the pointer and marks the log
// uninitialized: begin items are rejected until an init item arrives.
module flash_ring_log_writer_unit import flrw_pkg::*; #(
  parameter int SECTOR_BYTES = 4096,
  parameter int SECTOR_TOTAL = 32768,
  parameter int MAX_PAYLOAD  = 2048
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // start_address[26:0], scan_found[27], record_type[35:28], stamp[67:36],
  // payload_length[83:68], payload_byte[91:84], zero fill above
  input  logic [95:0] s_tdata,
  // operation[1:0]
  input  logic [1:0]  s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // flash_address[26:0], write_data[34:27], zero fill above
  output logic [39:0] m_tdata,
  // command[1:0]
  output logic [1:0]  m_tuser,
  output logic        m_tlast
);

  logic      push;
  flrw_job_t push_job;
  logic      q_full;
  logic      pop;
  logic      head_valid;
  flrw_job_t head_job;

  flrw_front #(
    .SECTOR_BYTES (SECTOR_BYTES),
    .SECTOR_TOTAL (SECTOR_TOTAL),
    .MAX_PAYLOAD  (MAX_PAYLOAD)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .q_full   (q_full),
    .push     (push),
    .job      (push_job)
  );

  flrw_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_job   (push_job),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_job   (head_job)
  );

  flrw_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_job   (head_job),
    .pop        (pop),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tuser    (m_tuser),
    .m_tlast    (m_tlast)
  );

endmodule

/* rtl/core/flrw_front.sv */
// front end: accepts items, keeps the log pointer and record state, builds jobs
module flrw_front import flrw_pkg::*; #(
  parameter int SECTOR_BYTES = 4096,
  parameter int SECTOR_TOTAL = 32768,
  parameter int MAX_PAYLOAD  = 2048
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [95:0] s_tdata,
  input  logic [1:0]  s_tuser,
  input  logic        q_full,
  output logic        push,
  output flrw_job_t   job
);

  // sector size is a power of two
  localparam int SECT_SH = $clog2(SECTOR_BYTES);
  localparam int SUM_W   = 40;
  localparam logic [SUM_W-1:0] RING = SUM_W'(SECTOR_BYTES) * SUM_W'(SECTOR_TOTAL);

  logic [ADDR_W-1:0] wp, wp_next;
  logic              ready_flag, ready_flag_next;
  logic [11:0]       bytes_left, bytes_left_next;
  logic              in_record, in_record_next;
  logic [7:0]        running_xor, running_xor_next;

  flrw_op_t          op;
  logic [ADDR_W-1:0] start_address;
  logic              scan_found;
  logic [7:0]        record_type;
  logic [31:0]       stamp;
  logic [15:0]       payload_length;
  logic [7:0]        payload_byte;

  logic [SUM_W-1:0]  rec_end_excl;
  logic [ADDR_W-1:0] wp_wrap;
  logic [SUM_W-1:0]  end_addr;
  logic              erase_cond;
  logic [7:0]        xor_new;
  logic              accept;
  logic              produce;

  assign op             = flrw_op_t'(s_tuser);
  assign start_address  = s_tdata[26:0];
  assign scan_found     = s_tdata[27];
  assign record_type    = s_tdata[35:28];
  assign stamp          = s_tdata[67:36];
  assign payload_length = s_tdata[83:68];
  assign payload_byte   = s_tdata[91:84];

  assign s_tready = !q_full;
  assign accept   = s_tvalid && s_tready;
  // init with a scan hit leaves no word behind
  assign produce  = !((op == OP_INIT) && scan_found);
  assign push     = accept && produce;

  // wrap when header, payload and checksum would run past the ring end
  assign rec_end_excl = SUM_W'(wp) + SUM_W'(payload_length) + SUM_W'(JOB_BYTES);
  assign wp_wrap      = (rec_end_excl > RING) ? '0 : wp;
  assign end_addr     = SUM_W'(wp_wrap) + SUM_W'(payload_length) + SUM_W'(JOB_BYTES - 1);
  assign erase_cond   = (wp_wrap[SECT_SH-1:0] == '0) ||
                        ((SUM_W'(wp_wrap) >> SECT_SH) != (end_addr >> SECT_SH));
  assign xor_new      = running_xor ^ payload_byte;

  always_comb begin
    job              = '0;
    wp_next          = wp;
    ready_flag_next  = ready_flag;
    bytes_left_next  = bytes_left;
    in_record_next   = in_record;
    running_xor_next = running_xor;
    case (op)
      OP_INIT: begin
        in_record_next   = 1'b0;
        bytes_left_next  = '0;
        running_xor_next = '0;
        ready_flag_next  = 1'b1;
        if (scan_found) begin
          wp_next = start_address;
        end else begin
          wp_next   = '0;
          job.erase = 1'b1;
        end
      end
      OP_BEGIN: begin
        if (!ready_flag || (payload_length > 16'(MAX_PAYLOAD))) begin
          job.reject = 1'b1;
        end else begin
          job.erase      = erase_cond;
          job.erase_addr = ADDR_W'((end_addr >> SECT_SH) << SECT_SH);
          job.base       = wp_wrap;
          job.bytes[0]   = LOG_MAGIC[7:0];
          job.bytes[1]   = LOG_MAGIC[15:8];
          job.bytes[2]   = record_type;
          job.bytes[3]   = payload_length[7:0];
          job.bytes[4]   = payload_length[15:8];
          job.bytes[5]   = stamp[7:0];
          job.bytes[6]   = stamp[15:8];
          job.bytes[7]   = stamp[23:16];
          job.bytes[8]   = stamp[31:24];
          running_xor_next = '0;
          bytes_left_next  = payload_length[11:0];
          if (payload_length == '0) begin
            // empty record: zero checksum right after the header
            job.nbytes     = NB_W'(JOB_BYTES);
            wp_next        = wp_wrap + ADDR_W'(JOB_BYTES);
            in_record_next = 1'b0;
          end else begin
            job.nbytes     = NB_W'(JOB_BYTES - 1);
            wp_next        = wp_wrap + ADDR_W'(JOB_BYTES - 1);
            in_record_next = 1'b1;
          end
        end
      end
      OP_PAYLOAD: begin
        if (in_record) begin
          job.base        = wp;
          job.bytes[0]    = payload_byte;
          bytes_left_next = bytes_left - 12'd1;
          if (bytes_left == 12'd1) begin
            job.bytes[1]     = xor_new;
            job.nbytes       = NB_W'(2);
            wp_next          = wp + ADDR_W'(2);
            in_record_next   = 1'b0;
            running_xor_next = '0;
          end else begin
            job.nbytes       = NB_W'(1);
            wp_next          = wp + ADDR_W'(1);
            running_xor_next = xor_new;
          end
        end else begin
          job.reject = 1'b1;
        end
      end
      default: begin
        job.reject = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp          <= '0;
      ready_flag  <= 1'b0;
      bytes_left  <= '0;
      in_record   <= 1'b0;
      running_xor <= '0;
    end else if (accept) begin
      wp          <= wp_next;
      ready_flag  <= ready_flag_next;
      bytes_left  <= bytes_left_next;
      in_record   <= in_record_next;
      running_xor <= running_xor_next;
    end
  end

endmodule

/* rtl/core/flrw_queue.sv */
// short job queue between the front and back ends
module flrw_queue import flrw_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  flrw_job_t push_job,
  output logic      full,
  input  logic      pop,
  output logic      head_valid,
  output flrw_job_t head_job
);

  flrw_job_t          slots [QDEPTH];
  logic [QPTR_W-1:0]  wr_ptr;
  logic [QPTR_W-1:0]  rd_ptr;
  logic [QCNT_W-1:0]  count;
  logic               do_push;
  logic               do_pop;

  assign full       = (count == QCNT_W'(QDEPTH));
  assign head_valid = (count != '0);
  assign head_job   = slots[rd_ptr];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + QCNT_W'(1);
        2'b01:   count <= count - QCNT_W'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

/* rtl/core/flrw_back.sv */
// back end: expands each job into flash command words behind an output register
module flrw_back import flrw_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        head_valid,
  input  flrw_job_t   head_job,
  output logic        pop,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,
  output logic [1:0]  m_tuser,
  output logic        m_tlast
);

  logic              erase_done;
  logic [NB_W-1:0]   idx;
  logic              load;
  logic              in_erase;
  flrw_cmd_t         cur_cmd;
  logic [ADDR_W-1:0] cur_addr;
  logic [7:0]        cur_data;
  logic              cur_last;

  assign load     = head_valid && (!m_tvalid || m_tready);
  assign in_erase = head_job.erase && !erase_done;
  assign pop      = load && cur_last;

  always_comb begin
    if (head_job.reject) begin
      cur_cmd  = CMD_REJECT;
      cur_addr = '0;
      cur_data = '0;
      cur_last = 1'b1;
    end else if (in_erase) begin
      cur_cmd  = CMD_ERASE;
      cur_addr = head_job.erase_addr;
      cur_data = '0;
      cur_last = (head_job.nbytes == '0);
    end else begin
      cur_cmd  = CMD_WRITE;
      cur_addr = head_job.base + ADDR_W'(idx);
      cur_data = head_job.bytes[idx];
      cur_last = (idx == head_job.nbytes - NB_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      m_tdata <= {5'd0, cur_data, cur_addr};
      m_tuser <= cur_cmd;
      m_tlast <= cur_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid   <= 1'b0;
      erase_done <= 1'b0;
      idx        <= '0;
    end else begin
      if (load) begin
        m_tvalid <= 1'b1;
        if (cur_last) begin
          erase_done <= 1'b0;
          idx        <= '0;
        end else if (in_erase) begin
          erase_done <= 1'b1;
        end else begin
          idx <= idx + NB_W'(1);
        end
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

endmodule
